// ===== rtl/r2p_pkg.sv =====
`default_nettype none

package r2p_pkg;

   // Widths of the sample and of the fixed-point datapath.
   localparam int unsigned DATA_W  = 16;
   localparam int unsigned GUARD_W = 16;
   // Head room of four bits covers the CORDIC gain on a full-scale diagonal.
   localparam int unsigned XY_W    = DATA_W + GUARD_W + 4;
   localparam int unsigned ACC_W   = 32;
   localparam int unsigned ANG_W   = 16;
   localparam int unsigned TAB_LEN = 32;
   localparam int unsigned TAB_IW  = $clog2(TAB_LEN);

   // Reciprocal of the CORDIC gain, scaled by 2^32.
   localparam logic [31:0] INV_GAIN = 32'd2608131496;

   // Split point of the gain product and the widths that follow from it.
   localparam int unsigned PROD_SPLIT = 24;
   localparam int unsigned XU_W       = XY_W - 1;
   localparam int unsigned XHI_W      = XU_W - PROD_SPLIT;
   localparam int unsigned APROD_W    = XHI_W + 32;
   localparam int unsigned BPROD_W    = PROD_SPLIT + 32;
   localparam int unsigned BHI_W      = BPROD_W - PROD_SPLIT;
   localparam int unsigned SUM_W      = APROD_W + 1;
   localparam int unsigned MAGW_W     = SUM_W - PROD_SPLIT;

   // Angle codes for inputs that lie exactly on an axis.
   localparam logic [2:0] AXIS_NONE = 3'd0;
   localparam logic [2:0] AXIS_0    = 3'd1;
   localparam logic [2:0] AXIS_90   = 3'd2;
   localparam logic [2:0] AXIS_180  = 3'd3;
   localparam logic [2:0] AXIS_270  = 3'd4;

   localparam logic [ACC_W-1:0] HALF_TURN = 32'h8000_0000;

   typedef struct packed {
      logic signed [DATA_W-1:0] real_in;
      logic signed [DATA_W-1:0] imag_in;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] magnitude;
      logic [ANG_W-1:0]  angle;
      logic              zero_input;
   } rsp_type;

   // Side information that travels with a request down the pipeline.
   typedef struct packed {
      logic       zero;
      logic [2:0] axis;
   } flags_type;

   typedef struct packed {
      logic signed [XY_W-1:0] x;
      logic signed [XY_W-1:0] y;
      logic [ACC_W-1:0]       acc;
      flags_type              flags;
   } vec_type;

   // Arctangent of 2^-i, with 2^32 counts per turn.
   function automatic logic [ACC_W-1:0] atan_entry(input logic [TAB_IW-1:0] idx);
      logic [ACC_W-1:0] val;
      unique case (idx)
         5'd0:  val = 32'h20000000;
         5'd1:  val = 32'h12E4051E;
         5'd2:  val = 32'h09FB385B;
         5'd3:  val = 32'h051111D4;
         5'd4:  val = 32'h028B0D43;
         5'd5:  val = 32'h0145D7E1;
         5'd6:  val = 32'h00A2F61E;
         5'd7:  val = 32'h00517C55;
         5'd8:  val = 32'h0028BE53;
         5'd9:  val = 32'h00145F2F;
         5'd10: val = 32'h000A2F98;
         5'd11: val = 32'h000517CC;
         5'd12: val = 32'h00028BE6;
         5'd13: val = 32'h000145F3;
         5'd14: val = 32'h0000A2FA;
         5'd15: val = 32'h0000517D;
         5'd16: val = 32'h000028BE;
         5'd17: val = 32'h0000145F;
         5'd18: val = 32'h00000A30;
         5'd19: val = 32'h00000518;
         5'd20: val = 32'h0000028C;
         5'd21: val = 32'h00000146;
         5'd22: val = 32'h000000A3;
         5'd23: val = 32'h00000051;
         5'd24: val = 32'h00000029;
         5'd25: val = 32'h00000014;
         5'd26: val = 32'h0000000A;
         5'd27: val = 32'h00000005;
         5'd28: val = 32'h00000003;
         5'd29: val = 32'h00000001;
         5'd30: val = 32'h00000001;
         5'd31: val = 32'h00000000;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/r2p_stage.sv =====
`default_nettype none

module r2p_stage
   import r2p_pkg::*;
#(
   parameter int unsigned STEP = 0
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    up_valid,
   input  wire vec_type up_vec,
   output logic         up_ready,
   output logic         dn_valid,
   output vec_type      dn_vec,
   input  wire logic    dn_ready
);

   logic    valid_ff;
   vec_type vec_ff;
   vec_type vec_in;
   logic signed [XY_W-1:0] xs;
   logic signed [XY_W-1:0] ys;
   logic [ACC_W-1:0]       step_angle;

   // The stage takes a new request when it is empty or its content moves on.
   assign up_ready = !valid_ff || dn_ready;

   // One micro-rotation towards the positive real axis.
   always_comb begin
      xs         = up_vec.x >>> STEP;
      ys         = up_vec.y >>> STEP;
      step_angle = atan_entry(TAB_IW'(STEP));
      vec_in     = up_vec;
      if (!up_vec.y[XY_W-1]) begin
         vec_in.x   = up_vec.x + ys;
         vec_in.y   = up_vec.y - xs;
         vec_in.acc = up_vec.acc + step_angle;
      end else begin
         vec_in.x   = up_vec.x - ys;
         vec_in.y   = up_vec.y + xs;
         vec_in.acc = up_vec.acc - step_angle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         vec_ff <= vec_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_vec   = vec_ff;

endmodule

`default_nettype wire

// ===== rtl/rect_to_polar_unit.sv =====
`default_nettype none

// Rectangular to polar converter. Each request carries a signed 16-bit complex
// sample; each response gives its rounded modulus, its argument in [0, 2pi) with
// 65536 counts per turn, and a flag for an all-zero sample (angle then reads 0).
// Samples on an exact axis get an exact angle. The datapath is a fully pipelined
// CORDIC in vectoring mode with one register stage per micro-rotation, so one
// request is taken every clock unless a stalled response has filled the pipeline;
// there is one stage for the half-plane fold, ITERATIONS rotation stages, one for the
// gain multiply and one output register. Stages that hold no request keep filling
// while a response is stalled, so the pipeline only blocks the input once full.

module rect_to_polar_unit
   import r2p_pkg::*;
#(
   parameter int unsigned ITERATIONS = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_payload
);

   // Chain of pipeline positions: 0 is the fold stage, ITERATIONS the last rotation.
   logic    chain_valid [0:ITERATIONS];
   vec_type chain_vec   [0:ITERATIONS];
   logic    chain_ready [0:ITERATIONS];

   // Fold stage.
   logic    fold_valid_ff;
   vec_type fold_ff;
   vec_type fold_in;
   logic signed [XY_W-1:0] re_ext;
   logic signed [XY_W-1:0] im_ext;

   // Gain multiply stage.
   logic                   mul_valid_ff;
   logic                   mul_ready;
   logic [APROD_W-1:0]     mul_a_ff;
   logic [BHI_W-1:0]       mul_b_ff;
   logic [ACC_W-1:0]       mul_acc_ff;
   flags_type              mul_flags_ff;
   logic [XU_W-1:0]        xu;
   logic [APROD_W-1:0]     a_prod;
   logic [BPROD_W-1:0]     b_prod;

   // Output register.
   logic                   rsp_valid_ff;
   logic                   out_ready;
   rsp_type                rsp_ff;
   rsp_type                rsp_in;
   logic [SUM_W-1:0]       mag_sum;
   logic [MAGW_W-1:0]      mag_wide;
   logic [ACC_W-1:0]       acc_round;

   // Ready chain from the output back to the input.
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign mul_ready = !mul_valid_ff || out_ready;
   assign chain_ready[0]          = !fold_valid_ff || chain_ready[1];
   assign req_stall = !chain_ready[0];

   // Scale the sample, fold the left half plane onto the right one and classify it.
   always_comb begin
      re_ext = {{(XY_W - DATA_W - GUARD_W){req_payload.real_in[DATA_W-1]}},
                req_payload.real_in, {GUARD_W{1'b0}}};
      im_ext = {{(XY_W - DATA_W - GUARD_W){req_payload.imag_in[DATA_W-1]}},
                req_payload.imag_in, {GUARD_W{1'b0}}};
      fold_in.x          = re_ext;
      fold_in.y          = im_ext;
      fold_in.acc        = '0;
      fold_in.flags.zero = (req_payload.real_in == '0) && (req_payload.imag_in == '0);
      if (req_payload.real_in[DATA_W-1]) begin
         fold_in.x   = -re_ext;
         fold_in.y   = -im_ext;
         fold_in.acc = HALF_TURN;
      end
      priority if (req_payload.real_in == '0) begin
         fold_in.flags.axis = req_payload.imag_in[DATA_W-1] ? AXIS_270 : AXIS_90;
      end else if (req_payload.imag_in == '0) begin
         fold_in.flags.axis = req_payload.real_in[DATA_W-1] ? AXIS_180 : AXIS_0;
      end else begin
         fold_in.flags.axis = AXIS_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_valid_ff <= 1'b0;
      end else if (chain_ready[0]) begin
         fold_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (chain_ready[0] && req_valid) begin
         fold_ff <= fold_in;
      end
   end

   assign chain_valid[0] = fold_valid_ff;
   assign chain_vec[0]   = fold_ff;

   // One register stage per micro-rotation.
   for (genvar i = 0; i < ITERATIONS; i++) begin : g_rot
      if (i + 1 < ITERATIONS) begin : g_mid
         r2p_stage #(
            .STEP (i)
         ) u_stage (
            .clock    (clock),
            .reset    (reset),
            .up_valid (chain_valid[i]),
            .up_vec   (chain_vec[i]),
            .up_ready (chain_ready[i+1]),
            .dn_valid (chain_valid[i+1]),
            .dn_vec   (chain_vec[i+1]),
            .dn_ready (chain_ready[i+2])
         );
      end else begin : g_last
         logic last_up_ready;
         r2p_stage #(
            .STEP (i)
         ) u_stage (
            .clock    (clock),
            .reset    (reset),
            .up_valid (chain_valid[i]),
            .up_vec   (chain_vec[i]),
            .up_ready (last_up_ready),
            .dn_valid (chain_valid[i+1]),
            .dn_vec   (chain_vec[i+1]),
            .dn_ready (mul_ready)
         );
         if (i == 0) begin : g_single
            assign chain_ready[1] = last_up_ready;
         end else begin : g_multi
            assign chain_ready[i+1] = last_up_ready;
         end
      end
   end

   // Scale by the inverse gain in two partial products, split at bit 24.
   always_comb begin
      xu     = chain_vec[ITERATIONS].x[XY_W-1] ? '0 : chain_vec[ITERATIONS].x[XU_W-1:0];
      a_prod = APROD_W'(xu[XU_W-1:PROD_SPLIT]) * APROD_W'(INV_GAIN);
      b_prod = BPROD_W'(xu[PROD_SPLIT-1:0]) * BPROD_W'(INV_GAIN);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (mul_ready) begin
         mul_valid_ff <= chain_valid[ITERATIONS];
      end
   end

   always_ff @(posedge clock) begin
      if (mul_ready && chain_valid[ITERATIONS]) begin
         mul_a_ff     <= a_prod;
         mul_b_ff     <= b_prod[BPROD_W-1:PROD_SPLIT];
         mul_acc_ff   <= chain_vec[ITERATIONS].acc;
         mul_flags_ff <= chain_vec[ITERATIONS].flags;
      end
   end

   // Round and saturate the modulus, round the angle and apply the axis and zero-input overrides.
   always_comb begin
      mag_sum   = SUM_W'(mul_a_ff) + SUM_W'(mul_b_ff) + (SUM_W'(1) << (PROD_SPLIT - 1));
      mag_wide  = mag_sum[SUM_W-1:PROD_SPLIT];
      acc_round = mul_acc_ff + (ACC_W'(1) << (ACC_W - ANG_W - 1));
      rsp_in.magnitude  = (|mag_wide[MAGW_W-1:DATA_W]) ? {DATA_W{1'b1}} : mag_wide[DATA_W-1:0];
      rsp_in.zero_input = 1'b0;
      unique case (mul_flags_ff.axis)
         AXIS_0:   rsp_in.angle = 16'd0;
         AXIS_90:  rsp_in.angle = 16'd16384;
         AXIS_180: rsp_in.angle = 16'd32768;
         AXIS_270: rsp_in.angle = 16'd49152;
         default:  rsp_in.angle = acc_round[ACC_W-1:ACC_W-ANG_W];
      endcase
      if (mul_flags_ff.zero) begin
         rsp_in.magnitude  = '0;
         rsp_in.angle      = '0;
         rsp_in.zero_input = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && mul_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire
